// ===== rtl/core/amal_pkg.sv =====
package amal_pkg;

    // Field widths.
    localparam int CW       = 24;
    localparam int ID_W     = 3;
    localparam int RANGE_W  = 25;
    localparam int DIFF_W   = 25;
    localparam int SQA_W    = 2 * RANGE_W;
    localparam int MUL_W    = 28;
    localparam int PROD_W   = 2 * MUL_W;
    localparam int SQ_W     = 54;
    localparam int SQ_ITER  = SQ_W / 2;
    localparam int SQ_CNT_W = 5;
    localparam int ROOT_W   = 28;
    localparam int NUM_W    = 52;
    localparam int Q_W      = 17;
    localparam int CX_W     = 28;
    localparam int Z_W      = 26;
    localparam int ANG_W    = 16;
    localparam int PROJ_W   = 26;
    localparam int STEP_W   = 4;
    localparam int NUM_ANCH = 6;
    localparam int CFG_IDX_W = 2;

    localparam logic [RANGE_W-1:0] RANGE_MAX  = {RANGE_W{1'b1}};
    localparam logic [Q_W-1:0]     Q_ONE      = 17'h10000;
    localparam logic [Z_W-1:0]     Z_QUARTER  = 26'd5898240;
    localparam logic [ANG_W-1:0]   ANGLE_HALF = 16'd23040;
    localparam logic [ANG_W-1:0]   ANGLE_FULL = 16'd46080;
    localparam logic [NUM_ANCH-1:0] FLAGS_ALL = {NUM_ANCH{1'b1}};

    localparam logic [CW-1:0] REF_X_RST    = 24'd5120;
    localparam logic [CW-1:0] REF_Y_RST    = 24'd5120;
    localparam logic [CW-1:0] REF_Z_RST    = 24'd9472;
    localparam logic [CW-1:0] BASELINE_RST = 24'd5120;

    // atan(2^-i) in degrees, Q16.
    localparam logic [22:0] ATAN_TBL [16] = '{
        23'd2949120, 23'd1740967, 23'd919879, 23'd466945,
        23'd234379,  23'd117304,  23'd58666,  23'd29335,
        23'd14668,   23'd7334,    23'd3667,   23'd1833,
        23'd917,     23'd458,     23'd229,    23'd115
    };

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_REF_X    = 2'd0,
        CFG_REF_Y    = 2'd1,
        CFG_REF_Z    = 2'd2,
        CFG_BASELINE = 2'd3
    } cfg_idx_t;

    typedef enum logic [1:0] {
        RES_WAIT   = 2'd0,
        RES_OK     = 2'd1,
        RES_NOTRI  = 2'd2,
        RES_BADTAG = 2'd3
    } res_code_t;

    typedef enum logic [3:0] {
        MUL_NONE, MUL_DX, MUL_DY, MUL_DZ, MUL_A, MUL_B, MUL_C,
        MUL_DEN, MUL_Q, MUL_P
    } mul_sel_t;

    typedef enum logic [1:0] {
        ACC_NONE, ACC_LOAD, ACC_ADD
    } acc_op_t;

    typedef enum logic [1:0] {
        SQ_ACC, SQ_XQ, SQ_XV, SQ_SIN
    } sq_src_t;

    typedef enum logic [4:0] {
        ST_IDLE, ST_DECODE, ST_MUL_X, ST_MUL_Y, ST_MUL_Z, ST_SUM,
        ST_SQ_GO, ST_SQ_WAIT, ST_STORE_D, ST_CHECK,
        ST_MUL_A, ST_MUL_B, ST_MUL_C, ST_XCALC, ST_STORE_R, ST_STORE_S,
        ST_MUL_DEN, ST_DEN, ST_DIV_INIT, ST_DIV, ST_MUL_Q, ST_STORE_SIN,
        ST_CORDIC, ST_ANGLE, ST_MUL_P, ST_FINAL, ST_RESULT
    } state_t;

    typedef struct packed {
        logic              load_in;
        mul_sel_t          mul_sel;
        acc_op_t           acc_op;
        logic              sq_start;
        sq_src_t           sq_src;
        logic              store_d;
        logic              store_sqa;
        logic              store_sqb;
        logic              xcalc;
        logic              store_r;
        logic              store_s;
        logic              den_load;
        logic              div_init;
        logic              div_step;
        logic              sin_store;
        logic              cordic_step;
        logic              angle_store;
        logic              final_calc;
        logic              emit;
        res_code_t         code;
        logic              pair;
        logic [STEP_W-1:0] step;
    } dp_cmd_t;

    typedef struct packed {
        logic tag_bad;
        logic full;
        logic tri_ok;
        logic sq_busy;
        logic div_sat;
        logic out_busy;
    } dp_stat_t;

    function automatic logic is_tri(input logic [RANGE_W-1:0] a,
                                    input logic [RANGE_W-1:0] b,
                                    input logic [RANGE_W-1:0] c);
        logic [RANGE_W:0] ab;
        logic [RANGE_W:0] ac;
        logic [RANGE_W:0] bc;
        ab = {1'b0, a} + {1'b0, b};
        ac = {1'b0, a} + {1'b0, c};
        bc = {1'b0, b} + {1'b0, c};
        return (a != '0) && (b != '0) && (c != '0) && (ab > {1'b0, c})
            && (ac > {1'b0, b}) && (bc > {1'b0, a});
    endfunction

    function automatic logic [RANGE_W-1:0] sat_range(input logic [ROOT_W-1:0] v);
        return (v > ROOT_W'(RANGE_MAX)) ? RANGE_MAX : v[RANGE_W-1:0];
    endfunction

endpackage

// ===== rtl/core/amal_if.sv =====
interface amal_pkt_if;
    logic                           valid;
    logic                           ready;
    logic [amal_pkg::ID_W-1:0]      anchor_id;
    logic signed [amal_pkg::CW-1:0] pos_x;
    logic signed [amal_pkg::CW-1:0] pos_y;
    logic signed [amal_pkg::CW-1:0] pos_z;

    modport source (output valid, anchor_id, pos_x, pos_y, pos_z, input ready);
    modport sink (input valid, anchor_id, pos_x, pos_y, pos_z, output ready);
endinterface

interface amal_res_if;
    logic                               valid;
    logic                               ready;
    logic [1:0]                         status;
    logic [amal_pkg::RANGE_W-1:0]       anchor_range;
    logic [amal_pkg::RANGE_W-1:0]       median_2d;
    logic [amal_pkg::RANGE_W-1:0]       median_3d;
    logic [amal_pkg::ANG_W-1:0]         angle_sigma;
    logic [amal_pkg::ANG_W-1:0]         angle_theta;
    logic signed [amal_pkg::PROJ_W-1:0] projection;

    modport source (output valid, status, anchor_range, median_2d, median_3d,
                    angle_sigma, angle_theta, projection, input ready);
    modport sink (input valid, status, anchor_range, median_2d, median_3d,
                  angle_sigma, angle_theta, projection, output ready);
endinterface

interface amal_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [amal_pkg::CFG_IDX_W-1:0] index;
    logic [amal_pkg::CW-1:0]        data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/core/amal_sqrt.sv =====
module amal_sqrt (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [amal_pkg::SQ_W-1:0]     operand,
    output logic                          busy,
    output logic [amal_pkg::ROOT_W-1:0]   root
);

    // Bit-pair square root, one result bit per cycle, then a final rounding step.
    logic [amal_pkg::SQ_W-1:0]     rem_reg, rem_next;
    logic [amal_pkg::SQ_W-1:0]     res_reg, res_next;
    logic [amal_pkg::SQ_W-1:0]     bit_reg, bit_next;
    logic [amal_pkg::SQ_CNT_W-1:0] cnt_reg, cnt_next;
    logic                          busy_reg, busy_next;
    logic [amal_pkg::ROOT_W-1:0]   root_reg, root_next;
    logic [amal_pkg::SQ_W-1:0]     trial;

    always_comb
    begin
        trial     = res_reg + bit_reg;
        rem_next  = rem_reg;
        res_next  = res_reg;
        bit_next  = bit_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        root_next = root_reg;
        if (start)
        begin
            rem_next  = operand;
            res_next  = '0;
            bit_next  = amal_pkg::SQ_W'(1) << (amal_pkg::SQ_W - 2);
            cnt_next  = amal_pkg::SQ_CNT_W'(amal_pkg::SQ_ITER);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (cnt_reg != '0)
            begin
                if (rem_reg >= trial)
                begin
                    rem_next = rem_reg - trial;
                    res_next = (res_reg >> 1) + bit_reg;
                end
                else
                begin
                    res_next = res_reg >> 1;
                end
                bit_next = bit_reg >> 2;
                cnt_next = cnt_reg - 1'b1;
            end
            else
            begin
                root_next = amal_pkg::ROOT_W'(res_reg)
                          + amal_pkg::ROOT_W'(rem_reg > res_reg);
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        res_reg  <= res_next;
        bit_reg  <= bit_next;
        root_reg <= root_next;
    end

    assign busy = busy_reg;
    assign root = root_reg;

endmodule

// ===== rtl/core/amal_datapath.sv =====
module amal_datapath (
    input  logic                                clk,
    input  logic                                rst_n,
    input  amal_pkg::dp_cmd_t                   cmd,
    output amal_pkg::dp_stat_t                  stat,
    input  logic                                cfg_valid,
    input  logic [amal_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [amal_pkg::CW-1:0]             cfg_data,
    input  logic [amal_pkg::ID_W-1:0]           anchor_id,
    input  logic signed [amal_pkg::CW-1:0]      pos_x,
    input  logic signed [amal_pkg::CW-1:0]      pos_y,
    input  logic signed [amal_pkg::CW-1:0]      pos_z,
    output logic                                res_valid,
    input  logic                                res_ready,
    output logic [1:0]                          status,
    output logic [amal_pkg::RANGE_W-1:0]        anchor_range,
    output logic [amal_pkg::RANGE_W-1:0]        median_2d,
    output logic [amal_pkg::RANGE_W-1:0]        median_3d,
    output logic [amal_pkg::ANG_W-1:0]          angle_sigma,
    output logic [amal_pkg::ANG_W-1:0]          angle_theta,
    output logic signed [amal_pkg::PROJ_W-1:0]  projection
);

    localparam int RW = amal_pkg::RANGE_W;

    // Configuration registers.
    logic [amal_pkg::CW-1:0] ref_x_reg, ref_y_reg, ref_z_reg, base_reg;

    // Captured packet.
    logic [amal_pkg::ID_W-1:0]      tag_reg;
    logic signed [amal_pkg::CW-1:0] px_reg, py_reg, pz_reg;

    // Anchor store.
    logic [RW-1:0]                 rng_reg [amal_pkg::NUM_ANCH];
    logic [amal_pkg::NUM_ANCH-1:0] flags_reg;

    // Working registers.
    logic [amal_pkg::PROD_W-1:0]      prod_reg;
    logic [amal_pkg::SQ_W-1:0]        acc_reg;
    logic [amal_pkg::SQA_W-1:0]       sqa_reg, sqb_reg;
    logic [amal_pkg::SQ_W-1:0]        xv_reg;
    logic signed [amal_pkg::NUM_W-1:0] num_reg;
    logic [amal_pkg::SQ_W-1:0]        den_reg, rem_reg;
    logic [amal_pkg::ROOT_W-1:0]      sroot_reg;
    logic [amal_pkg::Q_W-1:0]         qm_reg, sine_reg;
    logic signed [amal_pkg::CX_W-1:0] x_reg, y_reg;
    logic signed [amal_pkg::Z_W-1:0]  z_reg;
    logic [RW-1:0]                    range_reg, r1_reg, r2_reg;
    logic [amal_pkg::ANG_W-1:0]       sig_reg, th_reg;
    logic [amal_pkg::PROJ_W-1:0]      proj_reg;

    // Output word.
    logic                             ovalid_reg;
    logic [1:0]                       ostat_reg;
    logic [RW-1:0]                    orange_reg, or1_reg, or2_reg;
    logic [amal_pkg::ANG_W-1:0]       osig_reg, oth_reg;
    logic [amal_pkg::PROJ_W-1:0]      oproj_reg;

    logic                             sq_busy;
    logic [amal_pkg::ROOT_W-1:0]      root;
    logic [amal_pkg::SQ_W-1:0]        sq_operand;

    logic [amal_pkg::ID_W-1:0]        idx;
    logic [amal_pkg::CW-1:0]          rz;
    logic signed [amal_pkg::DIFF_W-1:0] dx, dy, dz;
    logic [amal_pkg::DIFF_W-1:0]      dxm, dym, dzm;
    logic [amal_pkg::MUL_W-1:0]       mul_a, mul_b;
    logic [amal_pkg::NUM_W-1:0]       mag;
    logic [amal_pkg::SQ_W-1:0]        rem2;
    logic                             qneg;
    logic [amal_pkg::Q_W-1:0]         sine_v;
    logic signed [amal_pkg::Z_W-1:0]  zc;
    logic [amal_pkg::Z_W-1:0]         zr;
    logic [amal_pkg::ANG_W-1:0]       ang;
    logic [amal_pkg::PROD_W-1:0]      prnd;
    logic [amal_pkg::PROJ_W-1:0]      pv;
    logic                             fwd;
    logic [RW-1:0]                    dva, dvb;

    amal_sqrt u_sqrt (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (cmd.sq_start),
        .operand (sq_operand),
        .busy    (sq_busy),
        .root    (root)
    );

    always_comb
    begin
        idx = tag_reg - 1'b1;
        rz  = (tag_reg <= amal_pkg::ID_W'(2)) ? '0 : ref_z_reg;
        dx  = {ref_x_reg[amal_pkg::CW-1], ref_x_reg} - {px_reg[amal_pkg::CW-1], px_reg};
        dy  = {ref_y_reg[amal_pkg::CW-1], ref_y_reg} - {py_reg[amal_pkg::CW-1], py_reg};
        dz  = {rz[amal_pkg::CW-1], rz} - {pz_reg[amal_pkg::CW-1], pz_reg};
        dxm = dx[amal_pkg::DIFF_W-1] ? -dx : dx;
        dym = dy[amal_pkg::DIFF_W-1] ? -dy : dy;
        dzm = dz[amal_pkg::DIFF_W-1] ? -dz : dz;
        dva = cmd.pair ? rng_reg[2] : rng_reg[0];
        dvb = cmd.pair ? rng_reg[3] : rng_reg[1];

        unique case (cmd.mul_sel)
            amal_pkg::MUL_DX:
            begin
                mul_a = amal_pkg::MUL_W'(dxm);
                mul_b = amal_pkg::MUL_W'(dxm);
            end
            amal_pkg::MUL_DY:
            begin
                mul_a = amal_pkg::MUL_W'(dym);
                mul_b = amal_pkg::MUL_W'(dym);
            end
            amal_pkg::MUL_DZ:
            begin
                mul_a = amal_pkg::MUL_W'(dzm);
                mul_b = amal_pkg::MUL_W'(dzm);
            end
            amal_pkg::MUL_A:
            begin
                mul_a = amal_pkg::MUL_W'(dva);
                mul_b = amal_pkg::MUL_W'(dva);
            end
            amal_pkg::MUL_B:
            begin
                mul_a = amal_pkg::MUL_W'(dvb);
                mul_b = amal_pkg::MUL_W'(dvb);
            end
            amal_pkg::MUL_C:
            begin
                mul_a = amal_pkg::MUL_W'(base_reg);
                mul_b = amal_pkg::MUL_W'(base_reg);
            end
            amal_pkg::MUL_DEN:
            begin
                mul_a = amal_pkg::MUL_W'(base_reg);
                mul_b = sroot_reg;
            end
            amal_pkg::MUL_Q:
            begin
                mul_a = amal_pkg::MUL_W'(qm_reg);
                mul_b = amal_pkg::MUL_W'(qm_reg);
            end
            amal_pkg::MUL_P:
            begin
                mul_a = amal_pkg::MUL_W'(r2_reg);
                mul_b = amal_pkg::MUL_W'(sine_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase

        unique case (cmd.sq_src)
            amal_pkg::SQ_ACC: sq_operand = acc_reg;
            amal_pkg::SQ_XQ:  sq_operand = xv_reg >> 2;
            amal_pkg::SQ_XV:  sq_operand = xv_reg;
            default:
                sq_operand = (amal_pkg::SQ_W'(1) << 32) - prod_reg[amal_pkg::SQ_W-1:0];
        endcase

        mag    = num_reg[amal_pkg::NUM_W-1] ? -num_reg : num_reg;
        rem2   = {rem_reg[amal_pkg::SQ_W-2:0], 1'b0};
        qneg   = num_reg[amal_pkg::NUM_W-1] && (qm_reg != '0);
        sine_v = root[amal_pkg::Q_W-1:0];

        // Round the Q16 angle to Q7 and keep it within half a turn.
        zc  = z_reg[amal_pkg::Z_W-1] ? '0 : z_reg;
        zr  = (amal_pkg::Z_W'(zc) + amal_pkg::Z_W'(256)) >> 9;
        ang = (zr > amal_pkg::Z_W'(amal_pkg::ANGLE_HALF)) ? amal_pkg::ANGLE_HALF
                                                          : zr[amal_pkg::ANG_W-1:0];

        prnd = (prod_reg + amal_pkg::PROD_W'(32768)) >> 16;
        pv   = prnd[amal_pkg::PROJ_W-1:0];
        fwd  = rng_reg[5] > rng_reg[4];

        stat.tag_bad  = (tag_reg == '0) || (tag_reg == amal_pkg::ID_W'(7));
        stat.full     = (flags_reg == amal_pkg::FLAGS_ALL);
        stat.tri_ok   = amal_pkg::is_tri(rng_reg[0], rng_reg[1], RW'(base_reg))
                     && amal_pkg::is_tri(rng_reg[2], rng_reg[3], RW'(base_reg));
        stat.sq_busy  = sq_busy;
        stat.div_sat  = (den_reg == '0) || (amal_pkg::SQ_W'(mag) >= den_reg);
        stat.out_busy = ovalid_reg && !res_ready;
    end

    // Configuration and control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ref_x_reg  <= amal_pkg::REF_X_RST;
            ref_y_reg  <= amal_pkg::REF_Y_RST;
            ref_z_reg  <= amal_pkg::REF_Z_RST;
            base_reg   <= amal_pkg::BASELINE_RST;
            flags_reg  <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                unique case (amal_pkg::cfg_idx_t'(cfg_index))
                    amal_pkg::CFG_REF_X:    ref_x_reg <= cfg_data;
                    amal_pkg::CFG_REF_Y:    ref_y_reg <= cfg_data;
                    amal_pkg::CFG_REF_Z:    ref_z_reg <= cfg_data;
                    amal_pkg::CFG_BASELINE: base_reg  <= cfg_data;
                    default:                base_reg  <= base_reg;
                endcase
            end
            if (cmd.store_d)
            begin
                flags_reg[idx] <= 1'b1;
            end
            if (cmd.emit)
            begin
                ovalid_reg <= 1'b1;
            end
            else if (res_ready)
            begin
                ovalid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            tag_reg <= anchor_id;
            px_reg  <= pos_x;
            py_reg  <= pos_y;
            pz_reg  <= pos_z;
        end
        if (cmd.mul_sel != amal_pkg::MUL_NONE)
        begin
            prod_reg <= amal_pkg::PROD_W'(mul_a) * amal_pkg::PROD_W'(mul_b);
        end
        if (cmd.acc_op == amal_pkg::ACC_LOAD)
        begin
            acc_reg <= prod_reg[amal_pkg::SQ_W-1:0];
        end
        else if (cmd.acc_op == amal_pkg::ACC_ADD)
        begin
            acc_reg <= acc_reg + prod_reg[amal_pkg::SQ_W-1:0];
        end
        if (cmd.store_d)
        begin
            rng_reg[idx] <= amal_pkg::sat_range(root);
            range_reg    <= amal_pkg::sat_range(root);
        end
        if (cmd.store_sqa)
        begin
            sqa_reg <= prod_reg[amal_pkg::SQA_W-1:0];
        end
        if (cmd.store_sqb)
        begin
            sqb_reg <= prod_reg[amal_pkg::SQA_W-1:0];
        end
        if (cmd.xcalc)
        begin
            xv_reg  <= amal_pkg::SQ_W'({sqa_reg, 1'b0}) + amal_pkg::SQ_W'({sqb_reg, 1'b0})
                     - prod_reg[amal_pkg::SQ_W-1:0];
            num_reg <= $signed(amal_pkg::NUM_W'(sqb_reg)) - $signed(amal_pkg::NUM_W'(sqa_reg));
        end
        if (cmd.store_r)
        begin
            if (cmd.pair)
            begin
                r2_reg <= amal_pkg::sat_range(root);
            end
            else
            begin
                r1_reg <= amal_pkg::sat_range(root);
            end
        end
        if (cmd.store_s)
        begin
            sroot_reg <= root;
        end
        if (cmd.den_load)
        begin
            den_reg <= prod_reg[amal_pkg::SQ_W-1:0];
        end
        if (cmd.div_init)
        begin
            if (stat.div_sat)
            begin
                qm_reg <= ((den_reg == '0) && (mag == '0)) ? '0 : amal_pkg::Q_ONE;
            end
            else
            begin
                rem_reg <= amal_pkg::SQ_W'(mag);
                qm_reg  <= '0;
            end
        end
        if (cmd.div_step)
        begin
            if (rem2 >= den_reg)
            begin
                rem_reg <= rem2 - den_reg;
                qm_reg  <= {qm_reg[amal_pkg::Q_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= rem2;
                qm_reg  <= {qm_reg[amal_pkg::Q_W-2:0], 1'b0};
            end
        end
        if (cmd.sin_store)
        begin
            sine_reg <= sine_v;
            if (qneg)
            begin
                x_reg <= amal_pkg::CX_W'({sine_v, 8'h00});
                y_reg <= amal_pkg::CX_W'({qm_reg, 8'h00});
                z_reg <= amal_pkg::Z_QUARTER;
            end
            else
            begin
                x_reg <= amal_pkg::CX_W'({qm_reg, 8'h00});
                y_reg <= amal_pkg::CX_W'({sine_v, 8'h00});
                z_reg <= '0;
            end
        end
        if (cmd.cordic_step)
        begin
            if (y_reg > 0)
            begin
                x_reg <= x_reg + (y_reg >>> cmd.step);
                y_reg <= y_reg - (x_reg >>> cmd.step);
                z_reg <= z_reg + amal_pkg::Z_W'(amal_pkg::ATAN_TBL[cmd.step]);
            end
            else
            begin
                x_reg <= x_reg - (y_reg >>> cmd.step);
                y_reg <= y_reg + (x_reg >>> cmd.step);
                z_reg <= z_reg - amal_pkg::Z_W'(amal_pkg::ATAN_TBL[cmd.step]);
            end
        end
        if (cmd.angle_store)
        begin
            if (cmd.pair)
            begin
                th_reg <= ang;
            end
            else
            begin
                sig_reg <= ang;
            end
        end
        if (cmd.final_calc)
        begin
            if (fwd)
            begin
                proj_reg <= pv;
            end
            else
            begin
                sig_reg  <= amal_pkg::ANGLE_FULL - sig_reg;
                th_reg   <= amal_pkg::ANGLE_FULL - th_reg;
                proj_reg <= -pv;
            end
        end
        if (cmd.emit)
        begin
            ostat_reg  <= cmd.code;
            orange_reg <= (cmd.code == amal_pkg::RES_BADTAG) ? '0 : range_reg;
            or1_reg    <= (cmd.code == amal_pkg::RES_OK) ? r1_reg : '0;
            or2_reg    <= (cmd.code == amal_pkg::RES_OK) ? r2_reg : '0;
            osig_reg   <= (cmd.code == amal_pkg::RES_OK) ? sig_reg : '0;
            oth_reg    <= (cmd.code == amal_pkg::RES_OK) ? th_reg : '0;
            oproj_reg  <= (cmd.code == amal_pkg::RES_OK) ? proj_reg : '0;
        end
    end

    assign res_valid    = ovalid_reg;
    assign status       = ostat_reg;
    assign anchor_range = orange_reg;
    assign median_2d    = or1_reg;
    assign median_3d    = or2_reg;
    assign angle_sigma  = osig_reg;
    assign angle_theta  = oth_reg;
    assign projection   = oproj_reg;

endmodule

// ===== rtl/core/amal_ctrl.sv =====
module amal_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                pkt_valid,
    output logic                pkt_ready,
    input  amal_pkg::dp_stat_t  stat,
    output amal_pkg::dp_cmd_t   cmd
);

    amal_pkg::state_t                state_reg, state_next;
    amal_pkg::state_t                ret_reg, ret_next;
    amal_pkg::sq_src_t               src_reg, src_next;
    amal_pkg::res_code_t             code_reg, code_next;
    logic                            pair_reg, pair_next;
    logic [amal_pkg::STEP_W-1:0]     cnt_reg, cnt_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= amal_pkg::ST_IDLE;
            ret_reg   <= amal_pkg::ST_IDLE;
            src_reg   <= amal_pkg::SQ_ACC;
            code_reg  <= amal_pkg::RES_WAIT;
            pair_reg  <= 1'b0;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
            src_reg   <= src_next;
            code_reg  <= code_next;
            pair_reg  <= pair_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        ret_next    = ret_reg;
        src_next    = src_reg;
        code_next   = code_reg;
        pair_next   = pair_reg;
        cnt_next    = cnt_reg;
        pkt_ready   = 1'b0;
        cmd         = '0;
        cmd.mul_sel = amal_pkg::MUL_NONE;
        cmd.acc_op  = amal_pkg::ACC_NONE;
        cmd.sq_src  = src_reg;
        cmd.code    = code_reg;
        cmd.pair    = pair_reg;
        cmd.step    = cnt_reg;

        unique case (state_reg)
            amal_pkg::ST_IDLE:
            begin
                pkt_ready = 1'b1;
                if (pkt_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = amal_pkg::ST_DECODE;
                end
            end
            amal_pkg::ST_DECODE:
            begin
                if (stat.tag_bad)
                begin
                    code_next  = amal_pkg::RES_BADTAG;
                    state_next = amal_pkg::ST_RESULT;
                end
                else
                begin
                    state_next = amal_pkg::ST_MUL_X;
                end
            end
            amal_pkg::ST_MUL_X:
            begin
                cmd.mul_sel = amal_pkg::MUL_DX;
                state_next  = amal_pkg::ST_MUL_Y;
            end
            amal_pkg::ST_MUL_Y:
            begin
                cmd.mul_sel = amal_pkg::MUL_DY;
                cmd.acc_op  = amal_pkg::ACC_LOAD;
                state_next  = amal_pkg::ST_MUL_Z;
            end
            amal_pkg::ST_MUL_Z:
            begin
                cmd.mul_sel = amal_pkg::MUL_DZ;
                cmd.acc_op  = amal_pkg::ACC_ADD;
                state_next  = amal_pkg::ST_SUM;
            end
            amal_pkg::ST_SUM:
            begin
                cmd.acc_op = amal_pkg::ACC_ADD;
                src_next   = amal_pkg::SQ_ACC;
                ret_next   = amal_pkg::ST_STORE_D;
                state_next = amal_pkg::ST_SQ_GO;
            end
            amal_pkg::ST_SQ_GO:
            begin
                cmd.sq_start = 1'b1;
                state_next   = amal_pkg::ST_SQ_WAIT;
            end
            amal_pkg::ST_SQ_WAIT:
            begin
                if (!stat.sq_busy)
                begin
                    state_next = ret_reg;
                end
            end
            amal_pkg::ST_STORE_D:
            begin
                cmd.store_d = 1'b1;
                state_next  = amal_pkg::ST_CHECK;
            end
            amal_pkg::ST_CHECK:
            begin
                priority if (!stat.full)
                begin
                    code_next  = amal_pkg::RES_WAIT;
                    state_next = amal_pkg::ST_RESULT;
                end
                else if (!stat.tri_ok)
                begin
                    code_next  = amal_pkg::RES_NOTRI;
                    state_next = amal_pkg::ST_RESULT;
                end
                else
                begin
                    pair_next  = 1'b0;
                    state_next = amal_pkg::ST_MUL_A;
                end
            end
            amal_pkg::ST_MUL_A:
            begin
                cmd.mul_sel = amal_pkg::MUL_A;
                state_next  = amal_pkg::ST_MUL_B;
            end
            amal_pkg::ST_MUL_B:
            begin
                cmd.mul_sel   = amal_pkg::MUL_B;
                cmd.store_sqa = 1'b1;
                state_next    = amal_pkg::ST_MUL_C;
            end
            amal_pkg::ST_MUL_C:
            begin
                cmd.mul_sel   = amal_pkg::MUL_C;
                cmd.store_sqb = 1'b1;
                state_next    = amal_pkg::ST_XCALC;
            end
            amal_pkg::ST_XCALC:
            begin
                cmd.xcalc  = 1'b1;
                src_next   = amal_pkg::SQ_XQ;
                ret_next   = amal_pkg::ST_STORE_R;
                state_next = amal_pkg::ST_SQ_GO;
            end
            amal_pkg::ST_STORE_R:
            begin
                cmd.store_r = 1'b1;
                src_next    = amal_pkg::SQ_XV;
                ret_next    = amal_pkg::ST_STORE_S;
                state_next  = amal_pkg::ST_SQ_GO;
            end
            amal_pkg::ST_STORE_S:
            begin
                cmd.store_s = 1'b1;
                state_next  = amal_pkg::ST_MUL_DEN;
            end
            amal_pkg::ST_MUL_DEN:
            begin
                cmd.mul_sel = amal_pkg::MUL_DEN;
                state_next  = amal_pkg::ST_DEN;
            end
            amal_pkg::ST_DEN:
            begin
                cmd.den_load = 1'b1;
                state_next   = amal_pkg::ST_DIV_INIT;
            end
            amal_pkg::ST_DIV_INIT:
            begin
                cmd.div_init = 1'b1;
                cnt_next     = '0;
                state_next   = stat.div_sat ? amal_pkg::ST_MUL_Q : amal_pkg::ST_DIV;
            end
            amal_pkg::ST_DIV:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == {amal_pkg::STEP_W{1'b1}})
                begin
                    state_next = amal_pkg::ST_MUL_Q;
                end
            end
            amal_pkg::ST_MUL_Q:
            begin
                cmd.mul_sel = amal_pkg::MUL_Q;
                src_next    = amal_pkg::SQ_SIN;
                ret_next    = amal_pkg::ST_STORE_SIN;
                state_next  = amal_pkg::ST_SQ_GO;
            end
            amal_pkg::ST_STORE_SIN:
            begin
                cmd.sin_store = 1'b1;
                cnt_next      = '0;
                state_next    = amal_pkg::ST_CORDIC;
            end
            amal_pkg::ST_CORDIC:
            begin
                cmd.cordic_step = 1'b1;
                cnt_next        = cnt_reg + 1'b1;
                if (cnt_reg == {amal_pkg::STEP_W{1'b1}})
                begin
                    state_next = amal_pkg::ST_ANGLE;
                end
            end
            amal_pkg::ST_ANGLE:
            begin
                cmd.angle_store = 1'b1;
                if (!pair_reg)
                begin
                    pair_next  = 1'b1;
                    state_next = amal_pkg::ST_MUL_A;
                end
                else
                begin
                    state_next = amal_pkg::ST_MUL_P;
                end
            end
            amal_pkg::ST_MUL_P:
            begin
                cmd.mul_sel = amal_pkg::MUL_P;
                state_next  = amal_pkg::ST_FINAL;
            end
            amal_pkg::ST_FINAL:
            begin
                cmd.final_calc = 1'b1;
                code_next      = amal_pkg::RES_OK;
                state_next     = amal_pkg::ST_RESULT;
            end
            amal_pkg::ST_RESULT:
            begin
                if (!stat.out_busy)
                begin
                    cmd.emit   = 1'b1;
                    state_next = amal_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = amal_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/core/anchor_median_angle_locator.sv =====
// Anchor median angle locator.
// Position packets from six anchors arrive as words on the pkt channel
// (valid/ready; anchor_id, pos_x, pos_y, pos_z). Each accepted word yields
// exactly one result word on the res channel. Configuration words on the cfg
// channel (index 0..3: ref_x, ref_y, ref_z, baseline) are always taken and
// should only be sent while no packet is in flight.
// A bad tag goes straight to the result; a packet that leaves the anchor
// set incomplete or fails the triangle check stops after its range, and a
// packet that yields angles runs the full sequence. The block holds one
// packet at a time and takes no new one until its result is loaded. The
// work runs on the shared bit-serial square root (seven roots per full
// packet), the 16-step restoring divider and the 16-step CORDIC, all reused
// for both anchor pairs under one sequencer.
// The result sits in an output register; while the receiver stalls, the
// block still accepts and processes the next packet and then waits to load
// its result until the previous word is taken.
// Reset returns the configuration to its defaults, clears all received
// flags and leaves the channels idle; stored ranges are rewritten before use.
module anchor_median_angle_locator (
    input  logic       clk,
    input  logic       rst_n,
    amal_pkt_if.sink   pkt,
    amal_res_if.source res,
    amal_cfg_if.sink   cfg
);

    amal_pkg::dp_cmd_t  cmd;
    amal_pkg::dp_stat_t stat;

    // Configuration writes never stall.
    assign cfg.ready = 1'b1;

    amal_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .pkt_valid (pkt.valid),
        .pkt_ready (pkt.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    amal_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .cfg_valid    (cfg.valid),
        .cfg_index    (cfg.index),
        .cfg_data     (cfg.data),
        .anchor_id    (pkt.anchor_id),
        .pos_x        (pkt.pos_x),
        .pos_y        (pkt.pos_y),
        .pos_z        (pkt.pos_z),
        .res_valid    (res.valid),
        .res_ready    (res.ready),
        .status       (res.status),
        .anchor_range (res.anchor_range),
        .median_2d    (res.median_2d),
        .median_3d    (res.median_3d),
        .angle_sigma  (res.angle_sigma),
        .angle_theta  (res.angle_theta),
        .projection   (res.projection)
    );

endmodule

// ===== rtl/core/amal_checker.sv =====
module amal_checker (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                pkt_valid,
    input logic                                pkt_ready,
    input logic                                res_valid,
    input logic                                res_ready,
    input logic [1:0]                          status,
    input logic [amal_pkg::RANGE_W-1:0]        anchor_range,
    input logic [amal_pkg::RANGE_W-1:0]        median_2d,
    input logic [amal_pkg::RANGE_W-1:0]        median_3d,
    input logic [amal_pkg::ANG_W-1:0]          angle_sigma,
    input logic [amal_pkg::ANG_W-1:0]          angle_theta,
    input logic signed [amal_pkg::PROJ_W-1:0]  projection
);

    // A stalled result word holds: valid, status, range and sigma angle stay.
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(status)
            && $stable(anchor_range) && $stable(angle_sigma))
        else $error("result word changed while stalled");

    // One packet at a time: the input closes right after an accept.
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        pkt_valid && pkt_ready |=> !pkt_ready)
        else $error("packet accepted while another is in work");

    a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && (status == amal_pkg::RES_BADTAG) |->
            anchor_range == '0 && median_2d == '0 && median_3d == '0
            && angle_sigma == '0 && angle_theta == '0 && projection == '0)
        else $error("bad tag result carries data");

    a_short_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && (status == amal_pkg::RES_WAIT || status == amal_pkg::RES_NOTRI) |->
            median_2d == '0 && median_3d == '0 && angle_sigma == '0
            && angle_theta == '0 && projection == '0)
        else $error("incomplete result carries angle data");

    // Both angles are reflected together or not at all.
    a_angle_side: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && (status == amal_pkg::RES_OK) |->
            (angle_sigma <= amal_pkg::ANGLE_HALF && angle_theta <= amal_pkg::ANGLE_HALF)
            || (angle_sigma >= amal_pkg::ANGLE_HALF && angle_theta >= amal_pkg::ANGLE_HALF
                && angle_sigma <= amal_pkg::ANGLE_FULL
                && angle_theta <= amal_pkg::ANGLE_FULL))
        else $error("angles lie on different sides");

endmodule

bind anchor_median_angle_locator amal_checker u_amal_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .pkt_valid    (pkt.valid),
    .pkt_ready    (pkt.ready),
    .res_valid    (res.valid),
    .res_ready    (res.ready),
    .status       (res.status),
    .anchor_range (res.anchor_range),
    .median_2d    (res.median_2d),
    .median_3d    (res.median_3d),
    .angle_sigma  (res.angle_sigma),
    .angle_theta  (res.angle_theta),
    .projection   (res.projection)
);
